// ===== hdl/rthb_pkg.sv =====
// Shared types and widths for the byte RGB to HSV converter.
// Used by the channel interfaces and every module of the block.
package rthb_pkg;

   localparam int ChanW   = 8;   // width of one color channel
   localparam int QuoW    = 8;   // quotient bits, one divide stage per bit
   localparam int HueNumW = 11;  // hue numerator before scaling, below 6*255
   localparam int SatRemW = 16;  // 255*delta
   localparam int SatDivW = 8;   // max channel
   localparam int HueRemW = 19;  // 255*n
   localparam int HueDivW = 11;  // 6*delta

   typedef logic [ChanW-1:0] chan_type;

   typedef struct packed {
      chan_type             hi;
      chan_type             delta;
      logic [HueNumW-1:0]   n;
   } sect_type;

   typedef struct packed {
      logic [SatRemW-1:0] sat_rem;
      logic [SatDivW-1:0] sat_div;
      logic [HueRemW-1:0] hue_rem;
      logic [HueDivW-1:0] hue_div;
      logic [QuoW-1:0]    sat_q;
      logic [QuoW-1:0]    hue_q;
      chan_type           bright;
   } div_type;

endpackage

// ===== hdl/rthb_if.sv =====
// Valid/ready channel interfaces for the pixel input and the HSV result.
// Depends on rthb_pkg for the channel type.
interface rthb_pix_if;
   import rthb_pkg::*;
   logic     valid;
   logic     ready;
   chan_type red;
   chan_type green;
   chan_type blue;
   modport source (output valid, red, green, blue, input ready);
   modport sink (input valid, red, green, blue, output ready);
endinterface

interface rthb_hsv_if;
   import rthb_pkg::*;
   logic     valid;
   logic     ready;
   chan_type hue;
   chan_type saturation;
   chan_type brightness;
   modport source (output valid, hue, saturation, brightness, input ready);
   modport sink (input valid, hue, saturation, brightness, output ready);
endinterface

// ===== hdl/rthb_prep.sv =====
// Front end: max/min, hue sector numerator, then scaling into divide operands.
// Two register stages. Depends on rthb_pkg.
module rthb_prep (
   input  logic              clock,
   input  logic              reset,
   input  logic              in_valid,
   output logic              in_ready,
   input  rthb_pkg::chan_type red,
   input  rthb_pkg::chan_type green,
   input  rthb_pkg::chan_type blue,
   output logic              out_valid,
   input  logic              out_ready,
   output rthb_pkg::div_type out_data
);
   import rthb_pkg::*;

   logic     s1_valid_ff, s1_valid_in, s1_ready;
   sect_type s1_data_ff, s1_data_in, s1_calc;
   logic     s2_valid_ff, s2_valid_in, s2_ready;
   div_type  s2_data_ff, s2_data_in, s2_calc;

   assign s2_ready = !s2_valid_ff || out_ready;
   assign s1_ready = !s1_valid_ff || s2_ready;
   assign in_ready = s1_ready;

   // Stage 1: largest and smallest channel and the hue in sixths times delta.
   always_comb begin
      chan_type           hi;
      chan_type           lo;
      chan_type           d;
      logic [HueNumW-1:0] dw;
      logic [HueNumW-1:0] n;
      hi = red;
      if (green > hi) hi = green;
      if (blue > hi) hi = blue;
      lo = red;
      if (green < lo) lo = green;
      if (blue < lo) lo = blue;
      d  = hi - lo;
      dw = HueNumW'(d);
      // Red wins ties for the maximum, then green.
      if (red == hi) begin
         n = HueNumW'(green) - HueNumW'(blue);
         if (green < blue) n = n + (dw << 2) + (dw << 1);
      end else if (green == hi) begin
         n = (dw << 1) + HueNumW'(blue) - HueNumW'(red);
      end else begin
         n = (dw << 2) + HueNumW'(red) - HueNumW'(green);
      end
      s1_calc.hi    = hi;
      s1_calc.delta = d;
      s1_calc.n     = n;
   end

   // Stage 2: numerators times 255 and hue divisor 6*delta. Grey and black
   // pixels divide zero by one so both quotients come out zero.
   always_comb begin
      s2_calc.sat_q  = '0;
      s2_calc.hue_q  = '0;
      s2_calc.bright = s1_data_ff.hi;
      if (s1_data_ff.delta == '0) begin
         s2_calc.sat_rem = '0;
         s2_calc.sat_div = SatDivW'(1);
         s2_calc.hue_rem = '0;
         s2_calc.hue_div = HueDivW'(1);
      end else begin
         s2_calc.sat_rem = (SatRemW'(s1_data_ff.delta) << ChanW)
                           - SatRemW'(s1_data_ff.delta);
         s2_calc.sat_div = SatDivW'(s1_data_ff.hi);
         s2_calc.hue_rem = (HueRemW'(s1_data_ff.n) << ChanW) - HueRemW'(s1_data_ff.n);
         s2_calc.hue_div = (HueDivW'(s1_data_ff.delta) << 2)
                           + (HueDivW'(s1_data_ff.delta) << 1);
      end
   end

   assign s1_valid_in = s1_ready ? in_valid : s1_valid_ff;
   assign s1_data_in  = (s1_ready && in_valid) ? s1_calc : s1_data_ff;
   assign s2_valid_in = s2_ready ? s1_valid_ff : s2_valid_ff;
   assign s2_data_in  = (s2_ready && s1_valid_ff) ? s2_calc : s2_data_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
         s2_valid_ff <= s2_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      s1_data_ff <= s1_data_in;
      s2_data_ff <= s2_data_in;
   end

   assign out_valid = s2_valid_ff;
   assign out_data  = s2_data_ff;

endmodule

// ===== hdl/rthb_div.sv =====
// Pipelined restoring divider: one quotient bit per stage for saturation
// and hue in parallel, brightness carried alongside. Depends on rthb_pkg.
module rthb_div (
   input  logic              clock,
   input  logic              reset,
   input  logic              in_valid,
   output logic              in_ready,
   input  rthb_pkg::div_type in_data,
   output logic              out_valid,
   input  logic              out_ready,
   output rthb_pkg::div_type out_data
);
   import rthb_pkg::*;

   logic    v_ff    [QuoW];
   logic    v_in    [QuoW];
   div_type d_ff    [QuoW];
   div_type d_in    [QuoW];
   logic    rdy     [QuoW+1];

   assign rdy[QuoW] = out_ready;
   assign in_ready  = rdy[0];

   for (genvar k = 0; k < QuoW; k++) begin : g_stage
      localparam int Sh = QuoW - 1 - k;
      logic               prev_v;
      div_type            prev_d;
      div_type            calc;
      logic [SatRemW-1:0] sat_sh;
      logic [HueRemW-1:0] hue_sh;

      if (k == 0) begin : g_first
         assign prev_v = in_valid;
         assign prev_d = in_data;
      end else begin : g_next
         assign prev_v = v_ff[k-1];
         assign prev_d = d_ff[k-1];
      end

      assign sat_sh = SatRemW'(prev_d.sat_div) << Sh;
      assign hue_sh = HueRemW'(prev_d.hue_div) << Sh;

      // The quotient stays below 256, so the partial remainder never needs
      // a divisor shifted further than the top quotient bit.
      always_comb begin
         calc = prev_d;
         if (prev_d.sat_rem >= sat_sh) begin
            calc.sat_rem   = prev_d.sat_rem - sat_sh;
            calc.sat_q[Sh] = 1'b1;
         end
         if (prev_d.hue_rem >= hue_sh) begin
            calc.hue_rem   = prev_d.hue_rem - hue_sh;
            calc.hue_q[Sh] = 1'b1;
         end
      end

      assign rdy[k]  = !v_ff[k] || rdy[k+1];
      assign v_in[k] = rdy[k] ? prev_v : v_ff[k];
      assign d_in[k] = (rdy[k] && prev_v) ? calc : d_ff[k];

      always_ff @(posedge clock) begin
         if (reset) begin
            v_ff[k] <= 1'b0;
         end else begin
            v_ff[k] <= v_in[k];
         end
      end

      always_ff @(posedge clock) begin
         d_ff[k] <= d_in[k];
      end
   end

   assign out_valid = v_ff[QuoW-1];
   assign out_data  = d_ff[QuoW-1];

endmodule

// ===== hdl/rgb_to_hsv_byte.sv =====
// Byte RGB to HSV converter, top level. Built from two front-end
// stages (max/min and sector, then scaling) and eight divide stages, one
// quotient bit each. Throughput is one pixel per cycle; a stalled output
// holds only the stages behind it, and bubbles ahead of it still fill.
// Synchronous active-high reset clears every stage valid bit.
module rgb_to_hsv_byte (
   input  logic      clock,
   input  logic      reset,
   rthb_pix_if.sink  req_ch,
   rthb_hsv_if.source rsp_ch
);
   import rthb_pkg::*;

   logic    mid_valid;
   logic    mid_ready;
   div_type mid_data;
   div_type res_data;

   rthb_prep u_prep (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_ch.valid),
      .in_ready  (req_ch.ready),
      .red       (req_ch.red),
      .green     (req_ch.green),
      .blue      (req_ch.blue),
      .out_valid (mid_valid),
      .out_ready (mid_ready),
      .out_data  (mid_data)
   );

   rthb_div u_div (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (mid_valid),
      .in_ready  (mid_ready),
      .in_data   (mid_data),
      .out_valid (rsp_ch.valid),
      .out_ready (rsp_ch.ready),
      .out_data  (res_data)
   );

   assign rsp_ch.hue        = res_data.hue_q;
   assign rsp_ch.saturation = res_data.sat_q;
   assign rsp_ch.brightness = res_data.bright;

   // Zero saturation only comes from a grey or black pixel, whose hue is zero.
   a_grey_hue : assert property (@(posedge clock) disable iff (reset)
      rsp_ch.valid && (rsp_ch.saturation == '0) |-> rsp_ch.hue == '0)
      else $error("nonzero hue on a pixel with zero saturation");

   a_hue_range : assert property (@(posedge clock) disable iff (reset)
      rsp_ch.valid |-> rsp_ch.hue != '1)
      else $error("hue reached a full circle");

   a_black : assert property (@(posedge clock) disable iff (reset)
      rsp_ch.valid && (rsp_ch.brightness == '0) |-> rsp_ch.saturation == '0)
      else $error("nonzero saturation on a black pixel");

   a_reset_empty : assert property (@(posedge clock)
      reset |=> !rsp_ch.valid)
      else $error("result valid right after reset");

endmodule
